@@ rtl/toc_pkg.sv @@
// Shared types, character codes and sizes for the terminal output canonicaliser.
`default_nettype none

package toc_pkg;

   // Character codes that the block recognises or sends.
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TLD = 8'h7E;
   localparam logic [7:0] CHAR_DEL = 8'h7F;

   // Configuration register indexes.
   localparam logic [1:0] CSR_EXPAND_TABS = 2'd0;
   localparam logic [1:0] CSR_CR_AFTER_LF = 2'd1;
   localparam logic [1:0] CSR_FILL_COUNT  = 2'd2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 2;

   // Tab stops, column size and the most characters one request may cause.
   localparam int TAB_WIDTH   = 8;
   localparam int COL_WIDTH   = 10;
   localparam int MAX_OUT     = 8;
   localparam int REP_WIDTH   = $clog2(MAX_OUT + 1);
   localparam int FILL_WIDTH  = 2;
   localparam int CHAR_WIDTH  = 7;

   // Depth of the work queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // One unit of work: the lead character sent rep times, then an optional
   // carriage return, then del_cnt fill characters.
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] lead;
      logic [REP_WIDTH-1:0]  rep;
      logic                  add_cr;
      logic [FILL_WIDTH-1:0] del_cnt;
   } desc_type;

endpackage

`default_nettype wire

@@ rtl/toc_req_if.sv @@
// Request channel interface carrying one character bound for the terminal.
`default_nettype none

interface toc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

@@ rtl/toc_rsp_if.sv @@
// Response channel interface carrying one seven-bit character to the transmitter.
`default_nettype none

interface toc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_out;
   logic       last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/toc_front.sv @@
// Front end: configuration registers, column tracking and request classification.
`default_nettype none

module toc_front (
   input  wire                                  clock,
   input  wire                                  reset,
   toc_req_if.sink                              req_bus,
   input  wire                                  csr_we,
   input  wire [toc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire [toc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  wire                                  q_full,
   output logic                                 q_push,
   output toc_pkg::desc_type                    q_desc
);

   localparam logic [toc_pkg::COL_WIDTH-1:0] TabWidthCol = toc_pkg::COL_WIDTH'(toc_pkg::TAB_WIDTH);
   localparam logic [toc_pkg::COL_WIDTH-1:0] MaxOutCol   = toc_pkg::COL_WIDTH'(toc_pkg::MAX_OUT);

   logic                             expand_tabs_ff;
   logic                             cr_after_lf_ff;
   logic [toc_pkg::FILL_WIDTH-1:0]   fill_count_ff;
   logic [toc_pkg::COL_WIDTH-1:0]    column_ff;
   logic [toc_pkg::COL_WIDTH-1:0]    column_in;
   logic [toc_pkg::COL_WIDTH-1:0]    tab_cnt;
   logic                             fire;
   logic                             emit;
   toc_pkg::desc_type                desc;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         expand_tabs_ff <= 1'b1;
         cr_after_lf_ff <= 1'b1;
         fill_count_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            toc_pkg::CSR_EXPAND_TABS: expand_tabs_ff <= csr_wdata[0];
            toc_pkg::CSR_CR_AFTER_LF: cr_after_lf_ff <= csr_wdata[0];
            toc_pkg::CSR_FILL_COUNT:  fill_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A request is taken whenever the queue has room.
   assign req_bus.ready = !q_full;
   assign fire          = req_bus.valid && req_bus.ready;

   // Distance to the next tab stop, from one to the tab width.
   assign tab_cnt = TabWidthCol - (column_ff % TabWidthCol);

   // Classify the character into a unit of work and the new column.
   always_comb begin
      emit         = 1'b0;
      desc.lead    = req_bus.char_in[toc_pkg::CHAR_WIDTH-1:0];
      desc.rep     = toc_pkg::REP_WIDTH'(1);
      desc.add_cr  = 1'b0;
      desc.del_cnt = '0;
      column_in    = column_ff;
      case (req_bus.char_in)
         toc_pkg::CHAR_NUL: ;
         toc_pkg::CHAR_BS: begin
            if (column_ff != '0) begin
               emit      = 1'b1;
               column_in = column_ff - toc_pkg::COL_WIDTH'(1);
            end
         end
         toc_pkg::CHAR_TAB: begin
            emit = 1'b1;
            if (expand_tabs_ff) begin
               desc.lead = toc_pkg::CHAR_SP[toc_pkg::CHAR_WIDTH-1:0];
               desc.rep  = (tab_cnt > MaxOutCol) ? toc_pkg::REP_WIDTH'(toc_pkg::MAX_OUT)
                                                 : tab_cnt[toc_pkg::REP_WIDTH-1:0];
               column_in = column_ff + tab_cnt;
            end
         end
         toc_pkg::CHAR_LF: begin
            emit = 1'b1;
            if (cr_after_lf_ff) begin
               desc.add_cr  = 1'b1;
               desc.del_cnt = fill_count_ff;
               column_in    = '0;
            end
         end
         toc_pkg::CHAR_CR: begin
            emit         = 1'b1;
            desc.del_cnt = fill_count_ff;
            column_in    = '0;
         end
         default: begin
            // Printable characters pass through; everything else is dropped.
            if (req_bus.char_in inside {[toc_pkg::CHAR_SP:toc_pkg::CHAR_TLD]}) begin
               emit      = 1'b1;
               column_in = column_ff + toc_pkg::COL_WIDTH'(1);
            end
         end
      endcase
   end

   // The column moves only when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else if (fire) begin
         column_ff <= column_in;
      end
   end

   assign q_push = fire && emit;
   assign q_desc = desc;

endmodule

`default_nettype wire

@@ rtl/toc_queue.sv @@
// Short first-in first-out queue of work units between front and back.
`default_nettype none

module toc_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  toc_pkg::desc_type   push_desc,
   output logic                full,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output toc_pkg::desc_type   pop_desc
);

   toc_pkg::desc_type                 entry_ff [toc_pkg::QUEUE_DEPTH];
   logic [toc_pkg::QPTR_WIDTH-1:0]    wr_ptr_ff;
   logic [toc_pkg::QPTR_WIDTH-1:0]    rd_ptr_ff;
   logic [toc_pkg::QCNT_WIDTH-1:0]    count_ff;
   logic [toc_pkg::QCNT_WIDTH-1:0]    count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full      = (count_ff == toc_pkg::QCNT_WIDTH'(toc_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + toc_pkg::QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - toc_pkg::QCNT_WIDTH'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + toc_pkg::QPTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + toc_pkg::QPTR_WIDTH'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

@@ rtl/toc_back.sv @@
// Back end: plays a work unit out as characters, one per cycle unless stalled.
`default_nettype none

module toc_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   output logic                q_ready,
   input  toc_pkg::desc_type   q_desc,
   toc_rsp_if.source           rsp_bus
);

   localparam int RemWidth = toc_pkg::REP_WIDTH + 1;

   logic                              busy_ff;
   logic                              busy_in;
   logic [toc_pkg::CHAR_WIDTH-1:0]    lead_ff;
   logic [toc_pkg::REP_WIDTH-1:0]     rep_ff;
   logic [toc_pkg::REP_WIDTH-1:0]     rep_in;
   logic                              cr_ff;
   logic                              cr_in;
   logic [toc_pkg::FILL_WIDTH-1:0]    del_ff;
   logic [toc_pkg::FILL_WIDTH-1:0]    del_in;
   logic [RemWidth-1:0]               remaining;
   logic                              fire;
   logic                              is_last;
   logic                              load;

   // Characters still to send for the current unit.
   assign remaining = RemWidth'(rep_ff) + RemWidth'(cr_ff) + RemWidth'(del_ff);
   assign is_last   = (remaining == RemWidth'(1));

   // The working registers drive the response directly.
   assign rsp_bus.valid    = busy_ff;
   assign rsp_bus.last     = is_last;
   assign rsp_bus.char_out = (rep_ff != '0) ? lead_ff :
                             cr_ff ? toc_pkg::CHAR_CR[toc_pkg::CHAR_WIDTH-1:0] :
                                     toc_pkg::CHAR_DEL[toc_pkg::CHAR_WIDTH-1:0];

   assign fire    = rsp_bus.valid && rsp_bus.ready;
   assign q_ready = !busy_ff || (fire && is_last);
   assign load    = q_valid && q_ready;

   // Step through lead run, carriage return and fill in that order.
   always_comb begin
      busy_in = busy_ff;
      rep_in  = rep_ff;
      cr_in   = cr_ff;
      del_in  = del_ff;
      if (load) begin
         busy_in = 1'b1;
         rep_in  = q_desc.rep;
         cr_in   = q_desc.add_cr;
         del_in  = q_desc.del_cnt;
      end else if (fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end
         if (rep_ff != '0) begin
            rep_in = rep_ff - toc_pkg::REP_WIDTH'(1);
         end else if (cr_ff) begin
            cr_in = 1'b0;
         end else begin
            del_in = del_ff - toc_pkg::FILL_WIDTH'(1);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rep_ff  <= '0;
         cr_ff   <= 1'b0;
         del_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         rep_ff  <= rep_in;
         cr_ff   <= cr_in;
         del_ff  <= del_in;
      end
   end

   // The lead character is payload and needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         lead_ff <= q_desc.lead;
      end
   end

endmodule

`default_nettype wire

@@ rtl/terminal_output_canonicalizer.sv @@
// Top level of the terminal output canonicaliser: front, work queue and back.
`default_nettype none

// Each request character becomes zero to eight response characters, with the
// cursor column kept internally. The front takes one request per cycle while
// the four-entry work queue has room; characters that cause nothing (NUL,
// backspace at column zero, other control and high bytes) are accepted but
// push no work. The back sends one response character per cycle while the
// response channel is ready. A printable character causes one response
// character, an expanded tab up to eight, and a line feed up to five, with
// carriage return and three fill characters. The back's one-character-per-
// cycle output sets the sustained rate. Configuration registers take effect
// for requests accepted after the write.
module terminal_output_canonicalizer (
   input  wire                                 clock,
   input  wire                                 reset,
   toc_req_if.sink                             req_bus,
   toc_rsp_if.source                           rsp_bus,
   input  wire                                 csr_we,
   input  wire [toc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire [toc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic               q_full;
   logic               q_push;
   toc_pkg::desc_type  q_push_desc;
   logic               q_valid;
   logic               q_ready;
   toc_pkg::desc_type  q_pop_desc;

   // Request classification and column tracking.
   toc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_desc    (q_push_desc)
   );

   // Work queue between the two halves.
   toc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_desc  (q_pop_desc)
   );

   // Character play-out.
   toc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_desc  (q_pop_desc),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   // An idle back end must take queued work at once.
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && !rsp_bus.valid) |-> q_ready)
      else $error("back end idle while work is queued");

   // Work taken from the queue appears on the response channel next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> rsp_bus.valid)
      else $error("loaded work unit not presented");

   // A run of characters continues until its final character is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last) |=> rsp_bus.valid)
      else $error("character run broken before its final character");
`endif

endmodule

`default_nettype wire
